/* hw/rtl/awpt_pkg.sv */
`timescale 1ns / 1ps
package awpt_pkg;

  localparam int MAX_TEXT       = 256;
  localparam int MASK_WIDTH     = 32;
  localparam int POS_BITS       = $clog2(MAX_TEXT);
  localparam int LEN_BITS       = POS_BITS + 1;
  localparam int SCORE_BITS     = 16;
  localparam int CHUNK_BITS     = 3;
  localparam int CHUNK_POS_BITS = $clog2(MASK_WIDTH);
  localparam int WIN_BITS       = 8;
  localparam int THR_BITS       = 8;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 9;
  localparam int CNT_EXT_BITS   = 16;
  localparam int DEF_COUNT_BITS = 8;
  localparam int TAIL_SKIP      = 3;
  localparam int SMALL_TEXT     = 5;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RD_LAST, ST_SKIP, ST_WSCAN, ST_CSCAN, ST_UPDATE, ST_EMIT
  } awpt_state_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TEXT_LENGTH = 3'd0,
    CFG_LOOKAHEAD   = 3'd1,
    CFG_SKIP_THR    = 3'd2,
    CFG_PENALTY_THR = 3'd3
  } awpt_cfg_idx_t;

  // row description handed to the mask builder
  typedef struct packed {
    logic [LEN_BITS-1:0]   tl;
    logic [POS_BITS-1:0]   pick;
    logic [WIN_BITS-1:0]   window;
    logic [LEN_BITS-1:0]   clr_end;
    logic [CHUNK_BITS-1:0] chunk;
  } awpt_row_t;

  // a zero count never reaches a threshold
  function automatic logic reached(logic [CNT_EXT_BITS-1:0] cnt,
                                   logic [THR_BITS-1:0] thr);
    reached = (cnt != '0) && (cnt >= CNT_EXT_BITS'(thr));
  endfunction

endpackage

/* hw/rtl/awpt_score_mem.sv */
`timescale 1ns / 1ps
module awpt_score_mem
  import awpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [POS_BITS-1:0]   wr_addr,
  input  logic [SCORE_BITS-1:0] wr_data,
  input  logic [POS_BITS-1:0]   rd_addr,
  output logic [SCORE_BITS-1:0] rd_data
);

  logic [SCORE_BITS-1:0] mem [MAX_TEXT];
  logic [SCORE_BITS-1:0] rd_data_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/awpt_count_mem.sv */
`timescale 1ns / 1ps
module awpt_count_mem
  import awpt_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  clr,
  input  logic                  wr_en,
  input  logic [POS_BITS-1:0]   wr_addr,
  input  logic [COUNT_BITS-1:0] wr_data,
  input  logic [POS_BITS-1:0]   rd_addr,
  output logic [COUNT_BITS-1:0] rd_data
);

  logic [COUNT_BITS-1:0] mem [MAX_TEXT];
  logic [MAX_TEXT-1:0]   vld_r;
  logic [COUNT_BITS-1:0] rd_data_r;
  logic                  rd_vld_r;

  // entry storage with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // per-entry valid bits; an invalid entry reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[rd_addr] & ~clr;
      if (clr) begin
        vld_r <= '0;
      end else if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

/* hw/rtl/awpt_mask_gen.sv */
`timescale 1ns / 1ps
module awpt_mask_gen
  import awpt_pkg::*;
(
  input  awpt_row_t             row,
  output logic [MASK_WIDTH-1:0] mask
);

  logic [LEN_BITS-1:0] pick_w;
  logic [LEN_BITS-1:0] hist;
  logic [LEN_BITS:0]   reach;
  logic [LEN_BITS:0]   tl_m1;
  logic [LEN_BITS:0]   hi;
  logic                small_text;

  // shared row bounds
  always_comb begin
    pick_w     = LEN_BITS'(row.pick);
    hist       = (pick_w <= LEN_BITS'(1)) ? LEN_BITS'(1) : pick_w - LEN_BITS'(1);
    reach      = (LEN_BITS + 1)'(pick_w) + (LEN_BITS + 1)'(row.window);
    tl_m1      = (LEN_BITS + 1)'(row.tl) - (LEN_BITS + 1)'(1);
    hi         = (reach < tl_m1) ? reach : tl_m1;
    small_text = row.tl <= LEN_BITS'(SMALL_TEXT);
  end

  // one bit per position of this chunk
  always_comb begin
    logic [LEN_BITS-1:0] p;
    logic                on;
    for (int i = 0; i < MASK_WIDTH; i++) begin
      p  = LEN_BITS'({row.chunk, CHUNK_POS_BITS'(i)});
      on = small_text || (p == hist) || (p == pick_w) ||
           ((p > pick_w) && ((LEN_BITS + 1)'(p) <= hi));
      mask[i] = (p < row.tl) && (p >= row.clr_end) && on;
    end
  end

endmodule

/* hw/rtl/attention_window_prior_tracker_core.sv */
`timescale 1ns / 1ps
// Channel  | Ports                                      | Beat taken when
// ---------+--------------------------------------------+-------------------------
// input    | start, busy, in_score, in_last_score,      | start && !busy
//          | in_new_utterance                           |
// result   | out_valid, out_chunk_index, out_prior_mask,| every out_valid cycle
//          | out_attended_position, out_last_chunk      |
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data  | cfg_valid && cfg_ready
//
// A score beat without last_score leaves busy low.
// A last_score beat starts the pick: a count read and the skip check, a scan of the
// window (skipped when the window is empty), the count-table sweep over all MAX_TEXT
// entries through the single count memory port, an update step, then one mask chunk
// per cycle, with busy high until the last chunk has gone out.
// Synchronous active-low reset sets config to its defaults and clears counts (valid bits) and state.
// Results go out one per cycle and cannot be held off.
module attention_window_prior_tracker_core
  import awpt_pkg::*;
#(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [SCORE_BITS-1:0]    in_score,
  input  logic                     in_last_score,
  input  logic                     in_new_utterance,
  output logic                     out_valid,
  output logic [CHUNK_BITS-1:0]    out_chunk_index,
  output logic [MASK_WIDTH-1:0]    out_prior_mask,
  output logic [POS_BITS-1:0]      out_attended_position,
  output logic                     out_last_chunk,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  awpt_state_t state_r, state_nxt;
  logic [LEN_BITS-1:0]   text_len_r;
  logic [WIN_BITS-1:0]   window_r;
  logic [THR_BITS-1:0]   skip_thr_r, pen_thr_r;
  logic [LEN_BITS-1:0]   load_pos_r, load_pos_nxt;
  logic [POS_BITS-1:0]   last_r, last_nxt;
  logic [LEN_BITS-1:0]   start_r, start_nxt;
  logic [LEN_BITS-1:0]   wend_r, wend_nxt;
  logic [LEN_BITS-1:0]   rp_r, rp_nxt;
  logic [LEN_BITS-1:0]   dp_r, dp_nxt;
  logic                  dv_r, dv_nxt;
  logic [POS_BITS-1:0]   best_r, best_nxt;
  logic [SCORE_BITS-1:0] best_sc_r, best_sc_nxt;
  logic [POS_BITS-1:0]   pick_r, pick_nxt;
  logic                  fur_vld_r, fur_vld_nxt;
  logic [POS_BITS-1:0]   fur_r, fur_nxt;
  logic [COUNT_BITS-1:0] cnt_a_r, cnt_a_nxt;
  logic [LEN_BITS-1:0]   clr_end_r, clr_end_nxt;
  logic [CHUNK_BITS-1:0] chunk_r, chunk_nxt;

  logic                  accept;
  logic [LEN_BITS-1:0]   tl;
  logic                  sc_wr_en;
  logic [POS_BITS-1:0]   sc_wr_addr, sc_rd_addr;
  logic [SCORE_BITS-1:0] sc_rd;
  logic                  cnt_clr, cnt_wr_en;
  logic [POS_BITS-1:0]   cnt_rd_addr;
  logic [COUNT_BITS-1:0] cnt_wr_data, cnt_rd;
  awpt_row_t             row;

  assign accept    = start && !busy;
  assign busy      = state_r != ST_IDLE;
  assign cfg_ready = 1'b1;

  // effective text length: zero acts as one, clipped to MAX_TEXT
  always_comb begin
    if (text_len_r == '0) begin
      tl = LEN_BITS'(1);
    end else if (text_len_r > LEN_BITS'(MAX_TEXT)) begin
      tl = LEN_BITS'(MAX_TEXT);
    end else begin
      tl = text_len_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_len_r <= LEN_BITS'(256);
      window_r   <= WIN_BITS'(10);
      skip_thr_r <= THR_BITS'(8);
      pen_thr_r  <= THR_BITS'(15);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEXT_LENGTH: text_len_r <= cfg_data;
        CFG_LOOKAHEAD:   window_r   <= cfg_data[WIN_BITS-1:0];
        CFG_SKIP_THR:    skip_thr_r <= cfg_data[THR_BITS-1:0];
        CFG_PENALTY_THR: pen_thr_r  <= cfg_data[THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // score loading port
  assign sc_wr_en   = accept && (in_new_utterance || load_pos_r < LEN_BITS'(MAX_TEXT));
  assign sc_wr_addr = in_new_utterance ? '0 : load_pos_r[POS_BITS-1:0];
  assign sc_rd_addr = rp_r[POS_BITS-1:0];

  awpt_score_mem u_score_mem (
    .clk     (clk),
    .wr_en   (sc_wr_en),
    .wr_addr (sc_wr_addr),
    .wr_data (in_score),
    .rd_addr (sc_rd_addr),
    .rd_data (sc_rd)
  );

  assign cnt_clr     = accept && in_new_utterance;
  assign cnt_rd_addr = (state_r == ST_CSCAN) ? rp_r[POS_BITS-1:0] : last_nxt;
  assign cnt_wr_en   = state_r == ST_UPDATE;
  assign cnt_wr_data = (cnt_a_r == CNT_MAX) ? cnt_a_r : cnt_a_r + COUNT_BITS'(1);

  awpt_count_mem #(.COUNT_BITS(COUNT_BITS)) u_count_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (cnt_clr),
    .wr_en   (cnt_wr_en),
    .wr_addr (pick_r),
    .wr_data (cnt_wr_data),
    .rd_addr (cnt_rd_addr),
    .rd_data (cnt_rd)
  );

  // chunk builder
  always_comb begin
    row.tl      = tl;
    row.pick    = pick_r;
    row.window  = window_r;
    row.clr_end = clr_end_r;
    row.chunk   = chunk_r;
  end

  awpt_mask_gen u_mask_gen (
    .row  (row),
    .mask (out_prior_mask)
  );

  assign out_valid             = state_r == ST_EMIT;
  assign out_chunk_index       = chunk_r;
  assign out_attended_position = pick_r;
  assign out_last_chunk =
    LEN_BITS'({(CHUNK_BITS + 1)'(chunk_r) + (CHUNK_BITS + 1)'(1),
               CHUNK_POS_BITS'(0)}) >= tl;

  // step sequencer
  always_comb begin
    logic [LEN_BITS-1:0]   st;
    logic signed [LEN_BITS+1:0] wsum, wlim, wend;
    logic [POS_BITS-1:0]   fur2;
    logic                  fur2_vld;
    logic [LEN_BITS:0]     fend;

    state_nxt    = state_r;
    load_pos_nxt = load_pos_r;
    last_nxt     = last_r;
    start_nxt    = start_r;
    wend_nxt     = wend_r;
    rp_nxt       = rp_r;
    dp_nxt       = dp_r;
    dv_nxt       = 1'b0;
    best_nxt     = best_r;
    best_sc_nxt  = best_sc_r;
    pick_nxt     = pick_r;
    fur_vld_nxt  = fur_vld_r;
    fur_nxt      = fur_r;
    cnt_a_nxt    = cnt_a_r;
    clr_end_nxt  = clr_end_r;
    chunk_nxt    = chunk_r;
    st           = '0;
    wsum         = '0;
    wlim         = '0;
    wend         = '0;
    fur2         = fur_r;
    fur2_vld     = fur_vld_r;
    fend         = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_new_utterance) begin
            last_nxt     = '0;
            load_pos_nxt = LEN_BITS'(1);
          end else if (load_pos_r < LEN_BITS'(MAX_TEXT)) begin
            load_pos_nxt = load_pos_r + LEN_BITS'(1);
          end
          if (in_last_score) begin
            load_pos_nxt = '0;
            state_nxt    = ST_RD_LAST;
          end
        end
      end
      ST_RD_LAST: begin
        state_nxt = ST_SKIP;
      end
      ST_SKIP: begin
        // step off a sink, then clamp the window end before the tail
        st   = LEN_BITS'(last_r) +
               LEN_BITS'(reached(CNT_EXT_BITS'(cnt_rd), skip_thr_r));
        wsum = $signed((LEN_BITS + 2)'(st)) + $signed((LEN_BITS + 2)'(window_r));
        wlim = $signed((LEN_BITS + 2)'(tl)) - $signed((LEN_BITS + 2)'(TAIL_SKIP));
        wend = (wsum > wlim) ? wlim : wsum;
        fur_vld_nxt = 1'b0;
        if ($signed((LEN_BITS + 2)'(st)) >= wend) begin
          pick_nxt  = POS_BITS'(tl - LEN_BITS'(1));
          rp_nxt    = '0;
          state_nxt = ST_CSCAN;
        end else begin
          start_nxt = st;
          wend_nxt  = LEN_BITS'(wend);
          rp_nxt    = st;
          state_nxt = ST_WSCAN;
        end
      end
      ST_WSCAN: begin
        // first maximum over the window
        if (rp_r < wend_r) begin
          rp_nxt = rp_r + LEN_BITS'(1);
          dv_nxt = 1'b1;
          dp_nxt = rp_r;
        end
        if (dv_r && (dp_r == start_r || sc_rd > best_sc_r)) begin
          best_nxt    = dp_r[POS_BITS-1:0];
          best_sc_nxt = sc_rd;
        end
        if (rp_r >= wend_r && !dv_r) begin
          pick_nxt  = best_r;
          rp_nxt    = '0;
          state_nxt = ST_CSCAN;
        end
      end
      ST_CSCAN: begin
        // sweep counts for the furthest penalized entry
        if (rp_r < LEN_BITS'(MAX_TEXT)) begin
          rp_nxt = rp_r + LEN_BITS'(1);
          dv_nxt = 1'b1;
          dp_nxt = rp_r;
        end
        if (dv_r) begin
          if (reached(CNT_EXT_BITS'(cnt_rd), pen_thr_r)) begin
            fur_vld_nxt = 1'b1;
            fur_nxt     = dp_r[POS_BITS-1:0];
          end
          if (dp_r[POS_BITS-1:0] == pick_r) begin
            cnt_a_nxt = cnt_rd;
          end
        end
        if (rp_r >= LEN_BITS'(MAX_TEXT) && !dv_r) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // the pick's new count joins the penalty search
        last_nxt = pick_r;
        if (reached(CNT_EXT_BITS'(cnt_wr_data), pen_thr_r) &&
            (!fur_vld_r || pick_r > fur_r)) begin
          fur2     = pick_r;
          fur2_vld = 1'b1;
        end
        fend = (LEN_BITS + 1)'(fur2) + (LEN_BITS + 1)'(1);
        if (!fur2_vld) begin
          clr_end_nxt = '0;
        end else if (fend > (LEN_BITS + 1)'(tl)) begin
          clr_end_nxt = tl;
        end else begin
          clr_end_nxt = LEN_BITS'(fend);
        end
        chunk_nxt = '0;
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_last_chunk) begin
          state_nxt = ST_IDLE;
        end else begin
          chunk_nxt = chunk_r + CHUNK_BITS'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      load_pos_r <= '0;
      last_r     <= '0;
      dv_r       <= 1'b0;
      fur_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      load_pos_r <= load_pos_nxt;
      last_r     <= last_nxt;
      dv_r       <= dv_nxt;
      fur_vld_r  <= fur_vld_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    start_r   <= start_nxt;
    wend_r    <= wend_nxt;
    rp_r      <= rp_nxt;
    dp_r      <= dp_nxt;
    best_r    <= best_nxt;
    best_sc_r <= best_sc_nxt;
    pick_r    <= pick_nxt;
    fur_r     <= fur_nxt;
    cnt_a_r   <= cnt_a_nxt;
    clr_end_r <= clr_end_nxt;
    chunk_r   <= chunk_nxt;
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
module tb;
  import awpt_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;
  localparam int DRAIN_CYCLES = 300;

  typedef struct {
    logic [CHUNK_BITS-1:0] chunk;
    logic [MASK_WIDTH-1:0] mask;
    logic [POS_BITS-1:0]   pos;
    logic                  last;
  } chunk_beat_t;

  // predicts mask chunks from accepted score beats, checks them in order
  class prior_row_board;
    int unsigned          text_len = 256;
    int unsigned          window   = 10;
    int unsigned          skip_thr = 8;
    int unsigned          pen_thr  = 15;
    logic [15:0]          scores[MAX_TEXT];
    int unsigned          counts[MAX_TEXT];
    int unsigned          last_pos;
    int unsigned          load_pos;
    chunk_beat_t          pending_chunks[$];
    int                   errors;
    int                   chunks_seen;
    int                   steps_seen;

    function new();
      foreach (scores[i]) scores[i] = '0;
      foreach (counts[i]) counts[i] = 0;
      last_pos = 0;
      load_pos = 0;
      errors = 0;
      chunks_seen = 0;
      steps_seen = 0;
    endfunction

    function void set_reg(awpt_cfg_idx_t idx, int unsigned val);
      case (idx)
        CFG_TEXT_LENGTH: text_len = val & 'h1FF;
        CFG_LOOKAHEAD:   window   = val & 'hFF;
        CFG_SKIP_THR:    skip_thr = val & 'hFF;
        CFG_PENALTY_THR: pen_thr  = val & 'hFF;
        default: ;
      endcase
    endfunction

    function bit hit(int unsigned c, int unsigned thr);
      return c != 0 && c >= thr;
    endfunction

    function int eff_len();
      int t;
      t = text_len;
      if (t == 0) t = 1;
      if (t > MAX_TEXT) t = MAX_TEXT;
      return t;
    endfunction

    // note one accepted score beat; a final beat queues the row's chunks
    function void note_beat(logic [15:0] sc, bit fin, bit fresh);
      int tl, a, st, wend, best, p, furthest, nch;
      bit row[MAX_TEXT];
      chunk_beat_t cb;
      if (fresh) begin
        foreach (counts[i]) counts[i] = 0;
        last_pos = 0;
        load_pos = 0;
      end
      if (load_pos < MAX_TEXT) begin
        scores[load_pos] = sc;
        load_pos++;
      end
      if (!fin) return;
      load_pos = 0;
      steps_seen++;
      tl = eff_len();
      // pick: skip a sunk position, first max in the window
      st = last_pos;
      if (hit(counts[st], skip_thr)) st++;
      wend = st + window;
      if (wend > tl - 3) wend = tl - 3;
      if (st >= wend) a = tl - 1;
      else begin
        best = st;
        for (int t = st + 1; t < wend; t++)
          if (scores[t] > scores[best]) best = t;
        a = best;
      end
      if (counts[a] < 255) counts[a]++;
      last_pos = a;
      // row bits
      foreach (row[i]) row[i] = 0;
      if (tl <= SMALL_TEXT) begin
        for (int t = 0; t < tl; t++) row[t] = 1;
      end else begin
        p = (a - 1 < 1) ? 1 : a - 1;
        row[p] = 1;
        row[(a < tl - 1) ? a : tl - 1] = 1;
        for (int d = 1; d <= window; d++) begin
          p = (a + d > tl - 1) ? tl - 1 : a + d;
          row[p] = 1;
        end
      end
      furthest = -1;
      for (int t = 0; t < MAX_TEXT; t++)
        if (hit(counts[t], pen_thr)) furthest = t;
      for (int t = 0; t <= furthest && t < tl; t++) row[t] = 0;
      nch = (tl + MASK_WIDTH - 1) / MASK_WIDTH;
      for (int k = 0; k < nch; k++) begin
        cb.chunk = CHUNK_BITS'(k);
        cb.mask = '0;
        for (int i = 0; i < MASK_WIDTH; i++)
          if (k * MASK_WIDTH + i < tl && row[k * MASK_WIDTH + i]) cb.mask[i] = 1'b1;
        cb.pos = POS_BITS'(a);
        cb.last = (k == nch - 1);
        pending_chunks = {pending_chunks, cb};
      end
    endfunction

    function void check_chunk(chunk_beat_t got);
      chunk_beat_t exp_c;
      chunks_seen++;
      if (pending_chunks.size() == 0) begin
        $display("%0t: unexpected chunk %0d mask %h pos %0d last %0b", $time,
                 got.chunk, got.mask, got.pos, got.last);
        errors++;
        return;
      end
      exp_c = pending_chunks.pop_front();
      if (got.chunk !== exp_c.chunk) begin
        $display("%0t: chunk_index exp %0d got %0d", $time, exp_c.chunk, got.chunk);
        errors++;
      end
      if (got.mask !== exp_c.mask) begin
        $display("%0t: prior_mask exp %h got %h", $time, exp_c.mask, got.mask);
        errors++;
      end
      if (got.pos !== exp_c.pos) begin
        $display("%0t: attended_position exp %0d got %0d", $time, exp_c.pos, got.pos);
        errors++;
      end
      if (got.last !== exp_c.last) begin
        $display("%0t: last_chunk exp %0b got %0b", $time, exp_c.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [SCORE_BITS-1:0]    in_score;
  logic                     in_last_score;
  logic                     in_new_utterance;
  logic                     out_valid;
  logic [CHUNK_BITS-1:0]    out_chunk_index;
  logic [MASK_WIDTH-1:0]    out_prior_mask;
  logic [POS_BITS-1:0]      out_attended_position;
  logic                     out_last_chunk;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  attention_window_prior_tracker_core dut (.*);

  prior_row_board board;
  int             cycles;
  int             idle_pct;
  int             beats_sent;
  int             written_hi;   // positions 0..written_hi-1 have been loaded
  int             gen_load;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result monitor: every out_valid cycle is a beat
  always @(posedge clk) begin
    chunk_beat_t got;
    if (rst_n && out_valid) begin
      got.chunk = out_chunk_index;
      got.mask  = out_prior_mask;
      got.pos   = out_attended_position;
      got.last  = out_last_chunk;
      board.check_chunk(got);
    end
  end

  // sender goes quiet until every queued chunk has come out
  task automatic wait_drained();
    start <= 1'b0;
    while (board.pending_chunks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(awpt_cfg_idx_t idx, int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(val);
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
  endtask

  task automatic set_regs(int unsigned tl, int unsigned win, int unsigned skp,
                          int unsigned pen);
    wait_drained();
    write_reg(CFG_TEXT_LENGTH, tl);
    write_reg(CFG_LOOKAHEAD, win);
    write_reg(CFG_SKIP_THR, skp);
    write_reg(CFG_PENALTY_THR, pen);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_beat(logic [15:0] sc, bit fin, bit fresh);
    start            <= 1'b1;
    in_score         <= sc;
    in_last_score    <= fin;
    in_new_utterance <= fresh;
    do @(posedge clk); while (busy);
    board.note_beat(sc, fin, fresh);
    beats_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_score();
    case ($urandom_range(7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2, 3: return 16'($urandom_range(0, 3));   // ties
      default: return 16'($urandom);
    endcase
  endfunction

  // one decoder step of at least n beats; the step only ends once every
  // position the pick may read has been loaded
  task automatic run_step(int n, bit fresh, bit noisy);
    bit nu, fin;
    int i;
    i = 0;
    fin = 0;
    while (!fin) begin
      nu = (i == 0) ? fresh : (noisy && $urandom_range(99) < 3);
      if (nu) gen_load = 0;
      if (gen_load < MAX_TEXT) begin
        if (gen_load + 1 > written_hi) written_hi = gen_load + 1;
        gen_load++;
      end
      fin = (i >= n - 1) && (written_hi >= board.eff_len());
      send_beat(rand_score(), fin, nu);
      i++;
    end
    gen_load = 0;
  endtask

  task automatic run_phase(int unsigned tl, int unsigned win, int unsigned skp,
                           int unsigned pen, int steps, int maxn);
    int n;
    set_regs(tl, win, skp, pen);
    for (int s = 0; s < steps; s++) begin
      n = ($urandom_range(9) < 3) ? board.eff_len() : $urandom_range(1, maxn);
      run_step(n, $urandom_range(9) == 0, 1'b1);
      // once per run: hold the sender until the row is out
      if (s == steps / 2 && tl == 12) wait_drained();
    end
  endtask

  initial begin
    board = new();
    beats_sent = 0;
    written_hi = 0;
    gen_load = 0;
    idle_pct = 22;
    start <= 1'b0;
    in_score <= '0;
    in_last_score <= 1'b0;
    in_new_utterance <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_TEXT_LENGTH;
    cfg_data <= '0;
    rst_n <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: short text sets every row bit past the furthest penalized position
    set_regs(5, 1, 1, 1);
    run_step(5, 1'b1, 1'b0);
    run_step(5, 1'b0, 1'b0);
    // single position text, pick at zero
    set_regs(1, 0, 1, 255);
    run_step(1, 1'b0, 1'b0);
    run_step(1, 1'b1, 1'b0);
    // widest window, eager skip
    set_regs(8, 255, 1, 255);
    run_step(8, 1'b1, 1'b0);
    run_step(8, 1'b0, 1'b0);

    // random, sender idles now and then
    run_phase(12, 4, 2, 3, 6, 4);
    run_phase(0, 0, 0, 0, 4, 3);
    run_phase(40, 255, 3, 6, 3, 6);
    // sender idles most of the time
    idle_pct = 69;
    run_phase(20, 2, 255, 2, 6, 4);
    // back to back beats
    idle_pct = 0;
    run_phase(9, 2, 1, 2, 10, 3);

    wait_drained();
    $display("covered %0d score beats, %0d steps, %0d mask chunks", beats_sent,
             board.steps_seen, board.chunks_seen);
    $display("lengths 0..40, windows 0..255, thresholds 0..255, short and long steps");
    if (board.errors == 0 && board.pending_chunks.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* attention_window_prior_tracker_core.f */
hw/rtl/awpt_pkg.sv
hw/rtl/awpt_score_mem.sv
hw/rtl/awpt_count_mem.sv
hw/rtl/awpt_mask_gen.sv
hw/rtl/attention_window_prior_tracker_core.sv
sim/tb.sv
